// ===== rtl/kbd_sc_pkg.sv =====
// constants and key table for the set-1 scan code decoder
package kbd_sc_pkg;

  localparam int TABLE_ENTRIES = 89;

  localparam logic [7:0] SHIFT_L_MAKE   = 8'h2A;
  localparam logic [7:0] SHIFT_R_MAKE   = 8'h36;
  localparam logic [7:0] SHIFT_L_BREAK  = 8'hAA;
  localparam logic [7:0] SHIFT_R_BREAK  = 8'hB6;
  localparam logic [7:0] NUM_LOCK_MAKE  = 8'h45;
  localparam logic [7:0] SCRL_LOCK_MAKE = 8'h46;
  localparam logic [7:0] CAPS_LOCK_MAKE = 8'h3A;
  localparam logic [7:0] BREAK_MASK     = 8'h80;
  localparam logic [6:0] KEYPAD_FIRST   = 7'd71;
  localparam logic [6:0] KEYPAD_LAST    = 7'd83;

  localparam logic [7:0] NO_KEY_CODE = 8'h00;

  typedef struct packed {
    logic [7:0] alt;
    logic [7:0] base;
  } key_row_t;

  // two-column key table, base column and shifted column
  function automatic key_row_t key_rom(input logic [6:0] key);
    key_row_t row;
    row = '{alt: NO_KEY_CODE, base: NO_KEY_CODE};
    if (32'(key) < TABLE_ENTRIES) begin
      case (key)
        7'd0:  row = '{8'h00, 8'h00};
        7'd1:  row = '{8'h1B, 8'h1B};
        7'd2:  row = '{8'h21, 8'h31};
        7'd3:  row = '{8'h40, 8'h32};
        7'd4:  row = '{8'h23, 8'h33};
        7'd5:  row = '{8'h24, 8'h34};
        7'd6:  row = '{8'h25, 8'h35};
        7'd7:  row = '{8'h5E, 8'h36};
        7'd8:  row = '{8'h26, 8'h37};
        7'd9:  row = '{8'h2A, 8'h38};
        7'd10: row = '{8'h28, 8'h39};
        7'd11: row = '{8'h29, 8'h30};
        7'd12: row = '{8'h5F, 8'h2D};
        7'd13: row = '{8'h2B, 8'h3D};
        7'd14: row = '{8'h08, 8'h08};
        7'd15: row = '{8'h09, 8'h09};
        7'd16: row = '{8'h51, 8'h71};
        7'd17: row = '{8'h57, 8'h77};
        7'd18: row = '{8'h45, 8'h65};
        7'd19: row = '{8'h52, 8'h72};
        7'd20: row = '{8'h54, 8'h74};
        7'd21: row = '{8'h59, 8'h79};
        7'd22: row = '{8'h55, 8'h75};
        7'd23: row = '{8'h49, 8'h69};
        7'd24: row = '{8'h4F, 8'h6F};
        7'd25: row = '{8'h50, 8'h70};
        7'd26: row = '{8'h7B, 8'h5B};
        7'd27: row = '{8'h7D, 8'h5D};
        7'd28: row = '{8'h0A, 8'h0A};
        7'd29: row = '{8'h81, 8'h81};
        7'd30: row = '{8'h41, 8'h61};
        7'd31: row = '{8'h53, 8'h73};
        7'd32: row = '{8'h44, 8'h64};
        7'd33: row = '{8'h46, 8'h66};
        7'd34: row = '{8'h47, 8'h67};
        7'd35: row = '{8'h48, 8'h68};
        7'd36: row = '{8'h4A, 8'h6A};
        7'd37: row = '{8'h4B, 8'h6B};
        7'd38: row = '{8'h4C, 8'h6C};
        7'd39: row = '{8'h3A, 8'h3B};
        7'd40: row = '{8'h22, 8'h27};
        7'd41: row = '{8'h7E, 8'h60};
        7'd42: row = '{8'h82, 8'h82};
        7'd43: row = '{8'h7C, 8'h5C};
        7'd44: row = '{8'h5A, 8'h7A};
        7'd45: row = '{8'h58, 8'h78};
        7'd46: row = '{8'h43, 8'h63};
        7'd47: row = '{8'h56, 8'h76};
        7'd48: row = '{8'h42, 8'h62};
        7'd49: row = '{8'h4E, 8'h6E};
        7'd50: row = '{8'h4D, 8'h6D};
        7'd51: row = '{8'h3C, 8'h2C};
        7'd52: row = '{8'h3E, 8'h2E};
        7'd53: row = '{8'h3F, 8'h2F};
        7'd54: row = '{8'h83, 8'h83};
        7'd55: row = '{8'h2A, 8'h2A};
        7'd56: row = '{8'h85, 8'h85};
        7'd57: row = '{8'h20, 8'h20};
        7'd58: row = '{8'h86, 8'h86};
        7'd59: row = '{8'h87, 8'h87};
        7'd60: row = '{8'h88, 8'h88};
        7'd61: row = '{8'h89, 8'h89};
        7'd62: row = '{8'h8A, 8'h8A};
        7'd63: row = '{8'h8B, 8'h8B};
        7'd64: row = '{8'h8C, 8'h8C};
        7'd65: row = '{8'h8D, 8'h8D};
        7'd66: row = '{8'h8E, 8'h8E};
        7'd67: row = '{8'h8F, 8'h8F};
        7'd68: row = '{8'h90, 8'h90};
        7'd69: row = '{8'h91, 8'h91};
        7'd70: row = '{8'h92, 8'h92};
        7'd71: row = '{8'h37, 8'h93};
        7'd72: row = '{8'h38, 8'h94};
        7'd73: row = '{8'h39, 8'h95};
        7'd74: row = '{8'h2D, 8'h2D};
        7'd75: row = '{8'h34, 8'h96};
        7'd76: row = '{8'h35, 8'h97};
        7'd77: row = '{8'h36, 8'h98};
        7'd78: row = '{8'h2B, 8'h2B};
        7'd79: row = '{8'h31, 8'h99};
        7'd80: row = '{8'h32, 8'h9A};
        7'd81: row = '{8'h33, 8'h9B};
        7'd82: row = '{8'h30, 8'h9C};
        7'd83: row = '{8'h2E, 8'h9D};
        7'd87: row = '{8'h9E, 8'h9E};
        7'd88: row = '{8'h9F, 8'h9F};
        default: row = '{NO_KEY_CODE, NO_KEY_CODE};
      endcase
    end
    return row;
  endfunction

endpackage

// ===== rtl/keyboard_scan_code_to_ascii_top.sv =====
// set-1 scan code to key code decoder with shift and lock tracking
// Takes one raw set-1 scan code per word and returns exactly one result word for it: the key
// code from the two-column key table, a pressed flag (clear on break codes), and on a make code
// of num, caps or scroll lock the toggled LED bits with led_update set. A new scan code can be
// taken every clock cycle while results are taken; each word passes an input register and a
// result register, and while a finished result waits in the result register one more code can
// enter the input register. After reset num lock is on, shift, caps and scroll lock are off.
module keyboard_scan_code_to_ascii_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] scan_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] key_code,
  output logic       pressed,
  output logic       led_update,
  output logic [2:0] led_bits
);
  import kbd_sc_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_code;
  logic       advance;

  logic shift_held, num_lock_on, scroll_lock_on, caps_lock_on;
  logic shift_held_next, num_lock_on_next, scroll_lock_on_next, caps_lock_on_next;

  logic [6:0] key;
  key_row_t   row;
  logic       use_alt;
  logic [7:0] key_code_next;
  logic       led_update_next;
  logic [2:0] led_bits_next;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_comb begin
    key                 = s1_code[6:0];
    row                 = key_rom(key);
    shift_held_next     = shift_held;
    num_lock_on_next    = num_lock_on;
    scroll_lock_on_next = scroll_lock_on;
    caps_lock_on_next   = caps_lock_on;
    use_alt             = 1'b0;
    led_update_next     = 1'b0;
    led_bits_next       = 3'b000;
    if (s1_code inside {SHIFT_L_MAKE, SHIFT_R_MAKE}) begin
      shift_held_next = 1'b1;
    end else if (s1_code inside {SHIFT_L_BREAK, SHIFT_R_BREAK}) begin
      shift_held_next = 1'b0;
    end else if (s1_code inside {NUM_LOCK_MAKE, SCRL_LOCK_MAKE, CAPS_LOCK_MAKE}) begin
      if (s1_code == NUM_LOCK_MAKE) begin
        num_lock_on_next = !num_lock_on;
      end else if (s1_code == SCRL_LOCK_MAKE) begin
        scroll_lock_on_next = !scroll_lock_on;
      end else begin
        caps_lock_on_next = !caps_lock_on;
      end
      led_update_next = 1'b1;
      led_bits_next   = {caps_lock_on_next, num_lock_on_next, scroll_lock_on_next};
    end else if (key inside {[KEYPAD_FIRST:KEYPAD_LAST]}) begin
      use_alt = shift_held ^ num_lock_on;
    end else if (row.base != row.alt) begin
      use_alt = shift_held ^ caps_lock_on;
    end
    key_code_next = use_alt ? row.alt : row.base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      shift_held     <= 1'b0;
      num_lock_on    <= 1'b1;
      scroll_lock_on <= 1'b0;
      caps_lock_on   <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid      <= 1'b1;
        shift_held     <= shift_held_next;
        num_lock_on    <= num_lock_on_next;
        scroll_lock_on <= scroll_lock_on_next;
        caps_lock_on   <= caps_lock_on_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_code <= scan_code;
    end
    if (advance) begin
      key_code   <= key_code_next;
      pressed    <= (s1_code & BREAK_MASK) == 8'h00;
      led_update <= led_update_next;
      led_bits   <= led_bits_next;
    end
  end

endmodule

// ===== tb/sv/tb_keyboard_scan_code_to_ascii_top.sv =====
// self-checking testbench for the set-1 scan code decoder
`timescale 1ns / 1ps

module tb_keyboard_scan_code_to_ascii_top;
  import kbd_sc_pkg::*;

  typedef struct packed {
    logic [7:0] key_code;
    logic       pressed;
    logic       led_update;
    logic [2:0] led_bits;
  } key_result_t;

  // key 0 sits in the top byte
  localparam logic [89*8-1:0] BASE_TABLE = {
    128'h001B313233343536373839302D3D0809,
    128'h71776572747975696F705B5D0A816173,
    128'h646667686A6B6C3B2760825C7A786376,
    128'h626E6D2C2E2F832A8520868788898A8B,
    128'h8C8D8E8F9091929394952D9697982B99,
    72'h9A9B9C9D0000009E9F
  };

  localparam logic [89*8-1:0] SHIFT_TABLE = {
    128'h001B21402324255E262A28295F2B0809,
    128'h51574552545955494F507B7D0A814153,
    128'h444647484A4B4C3A227E827C5A584356,
    128'h424E4D3C3E3F832A8520868788898A8B,
    128'h8C8D8E8F9091923738392D3435362B31,
    72'h3233302E0000009E9F
  };

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic [7:0] scan_code  = 8'h00;
  logic       out_valid;
  logic       out_ready  = 1'b0;
  logic [7:0] key_code;
  logic       pressed;
  logic       led_update;
  logic [2:0] led_bits;

  logic shift_held;
  logic num_lock_on;
  logic scroll_lock_on;
  logic caps_lock_on;

  key_result_t pending_keys[$];
  key_result_t head_key;
  int errors             = 0;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_len           = 0;
  int hold_tag           = 0;
  int hold_seen          = 0;
  int hold_left          = 0;

  keyboard_scan_code_to_ascii_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .scan_code  (scan_code),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .key_code   (key_code),
    .pressed    (pressed),
    .led_update (led_update),
    .led_bits   (led_bits)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [7:0] table_lookup(input logic [6:0] key, input logic col);
    int idx;
    idx = int'(key);
    if (idx >= TABLE_ENTRIES || idx > 88) return NO_KEY_CODE;
    return col ? SHIFT_TABLE[(88 - idx) * 8 +: 8] : BASE_TABLE[(88 - idx) * 8 +: 8];
  endfunction

  // updates the shift and lock flags as the block would
  function automatic key_result_t decode_scan_code(input logic [7:0] code);
    key_result_t res;
    logic [6:0]  key;
    key = code[6:0];
    res = '0;
    res.pressed = ((code & BREAK_MASK) == 8'h00);
    if (code == SHIFT_L_MAKE || code == SHIFT_R_MAKE) begin
      shift_held = 1'b1;
      res.key_code = table_lookup(key, 1'b0);
    end else if (code == SHIFT_L_BREAK || code == SHIFT_R_BREAK) begin
      shift_held = 1'b0;
      res.key_code = table_lookup(key, 1'b0);
    end else if (code == NUM_LOCK_MAKE || code == SCRL_LOCK_MAKE || code == CAPS_LOCK_MAKE) begin
      if (code == NUM_LOCK_MAKE) num_lock_on = ~num_lock_on;
      else if (code == SCRL_LOCK_MAKE) scroll_lock_on = ~scroll_lock_on;
      else caps_lock_on = ~caps_lock_on;
      res.key_code   = table_lookup(key, 1'b0);
      res.led_update = 1'b1;
      res.led_bits   = {caps_lock_on, num_lock_on, scroll_lock_on};
    end else if (key >= KEYPAD_FIRST && key <= KEYPAD_LAST) begin
      res.key_code = table_lookup(key, shift_held ^ num_lock_on);
    end else if (table_lookup(key, 1'b0) != table_lookup(key, 1'b1)) begin
      res.key_code = table_lookup(key, shift_held ^ caps_lock_on);
    end else begin
      res.key_code = table_lookup(key, 1'b0);
    end
    return res;
  endfunction

  task automatic send_word(input logic [7:0] code);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    scan_code <= code;
    do @(posedge clk); while (!in_ready);
    pending_keys.push_back(decode_scan_code(code));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_scan_code();
    int pick;
    pick = $urandom_range(99);
    if (pick < 12) return 8'($urandom_range(255));
    if (pick < 20) begin
      case ($urandom_range(2))
        0:       return NUM_LOCK_MAKE;
        1:       return SCRL_LOCK_MAKE;
        default: return CAPS_LOCK_MAKE;
      endcase
    end
    if (pick < 32) begin
      case ($urandom_range(3))
        0:       return SHIFT_L_MAKE;
        1:       return SHIFT_R_MAKE;
        2:       return SHIFT_L_BREAK;
        default: return SHIFT_R_BREAK;
      endcase
    end
    return {1'($urandom_range(1)), 7'($urandom_range(88))};
  endfunction

  // typing: mostly a make then its break, sometimes a lone random code
  task automatic send_random_words(input int count);
    logic [7:0] code;
    int         sent;
    sent = 0;
    while (sent < count) begin
      code = random_scan_code();
      send_word(code);
      sent++;
      if (!code[7] && $urandom_range(99) < 60) begin
        send_word(code | BREAK_MASK);
        sent++;
      end
    end
  endtask

  task automatic test_directed_keys();
    logic [7:0] codes[$];
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    codes = '{8'h00, 8'h7F, 8'hFF, 8'h80, 8'h1E, 8'h9E, CAPS_LOCK_MAKE, 8'h1E,
              SHIFT_L_MAKE, 8'h1E, 8'h47, SHIFT_L_BREAK, 8'h47, NUM_LOCK_MAKE, 8'h47,
              8'hC7, SHIFT_R_MAKE, 8'h02, SHIFT_R_BREAK, SCRL_LOCK_MAKE, SCRL_LOCK_MAKE,
              8'hC5, 8'hBA, 8'h59, 8'h54, CAPS_LOCK_MAKE};
    foreach (codes[i]) send_word(codes[i]);
    wait_for_results();
  endtask

  task automatic test_streaming();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_random_words(400);
    wait_for_results();
  endtask

  task automatic test_sender_gaps();
    sender_idle_pct    = 60;
    receiver_stall_pct = 0;
    send_random_words(400);
    wait_for_results();
  endtask

  task automatic test_receiver_stalls();
    sender_idle_pct    = 0;
    receiver_stall_pct = 60;
    send_random_words(400);
    wait_for_results();
  endtask

  task automatic test_mixed_idling();
    sender_idle_pct    = 33;
    receiver_stall_pct = 33;
    send_random_words(400);
    wait_for_results();
  endtask

  task automatic test_output_hold_off();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_len = 300;
    hold_tag++;
    send_random_words(40);
    wait_for_results();
  endtask

  // long hold-offs are loaded from the test side, counted here
  always @(negedge clk) begin
    if (hold_tag != hold_seen) begin
      hold_seen = hold_tag;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_keys.size() == 0) begin
        $error("result word with no expectation: key_code %h", key_code);
        errors++;
      end else begin
        head_key = pending_keys.pop_front();
        if (key_code !== head_key.key_code) begin
          $error("key_code: expected %h, got %h", head_key.key_code, key_code);
          errors++;
        end
        if (pressed !== head_key.pressed) begin
          $error("pressed: expected %b, got %b", head_key.pressed, pressed);
          errors++;
        end
        if (led_update !== head_key.led_update) begin
          $error("led_update: expected %b, got %b", head_key.led_update, led_update);
          errors++;
        end
        if (led_bits !== head_key.led_bits) begin
          $error("led_bits: expected %b, got %b", head_key.led_bits, led_bits);
          errors++;
        end
      end
    end
  end

  initial begin
    shift_held     = 1'b0;
    num_lock_on    = 1'b1;
    scroll_lock_on = 1'b0;
    caps_lock_on   = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_keys();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();
    test_output_hold_off();
    @(negedge clk);
    in_valid <= 1'b0;
    wait_for_results();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_keys.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
